// File: rtl/hpt_pkg.sv
// hashed position table: shared types, constants and codes
// no dependencies; every other file imports this package

package hpt_pkg;

   // table geometry: the slot index is the low bits of the key word sum
   localparam int INDEX_BITS    = 12;
   localparam int TABLE_ENTRIES = 1 << INDEX_BITS;

   // field widths
   localparam int OPCODE_BITS   = 3;
   localparam int KEY_BITS      = 64;
   localparam int WORD_BITS     = 32;
   localparam int STATUS_BITS   = 2;

   // position limit, compared in 64 bits
   localparam int POSITION_BITS = 32;
   localparam logic [63:0] POS_LIMIT = (64'd1 << POSITION_BITS) - 64'd1;

   // slot markers
   localparam logic [WORD_BITS-1:0] SEARCH_MARK = '0;
   localparam logic [WORD_BITS-1:0] NULL_MARK   = '1;

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_GET   = 3'd0,
      OP_SET   = 3'd1,
      OP_UNSET = 3'd2,
      OP_RESET = 3'd3,
      OP_CLEAR = 3'd4
   } opcode_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_SEARCH  = 2'd2,
      ST_NOENT   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FSM_SWEEP,
      FSM_IDLE,
      FSM_LOOKUP,
      FSM_REPLY
   } fsm_state_type;

   // controller to datapath
   typedef struct packed {
      logic                  capture;      // latch request, read its slot
      logic                  execute;      // read-modify-write, load result
      logic                  sweep_write;  // zero one slot of a clear sweep
      logic [INDEX_BITS-1:0] sweep_addr;
      logic                  load_clear;   // load the reply to a clear
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;  // result register can take a new word this cycle
   } dp_status_type;

endpackage

// File: rtl/hpt_if.sv
// hashed position table: request and response channel interfaces
// depends on hpt_pkg for field widths

interface hpt_req_if;
   import hpt_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [OPCODE_BITS-1:0] opcode;
   logic [KEY_BITS-1:0]    key_word0;
   logic [KEY_BITS-1:0]    key_word1;
   logic [KEY_BITS-1:0]    key_word2;
   logic [KEY_BITS-1:0]    key_word3;
   logic [WORD_BITS-1:0]   new_position;

   modport source (output valid, opcode, key_word0, key_word1, key_word2, key_word3,
                   new_position, input ready);
   modport sink (input valid, opcode, key_word0, key_word1, key_word2, key_word3,
                 new_position, output ready);
endinterface

interface hpt_rsp_if;
   import hpt_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [STATUS_BITS-1:0] status;
   logic [WORD_BITS-1:0]   found_position;

   modport source (output valid, status, found_position, input ready);
   modport sink (input valid, status, found_position, output ready);
endinterface

// File: rtl/hpt_ctrl.sv
// hashed position table: controller state machine and sweep counter
// depends on hpt_pkg; drives the command struct of hpt_datapath

module hpt_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [hpt_pkg::OPCODE_BITS-1:0] req_opcode,
   output logic                         req_ready,
   input  hpt_pkg::dp_status_type       status,
   output hpt_pkg::ctrl_cmd_type        cmd
);
   import hpt_pkg::*;

   localparam logic [INDEX_BITS-1:0] LAST_SLOT = INDEX_BITS'(TABLE_ENTRIES - 1);

   fsm_state_type         state_ff, state_in;
   logic [INDEX_BITS-1:0] sweep_cnt_ff, sweep_cnt_in;
   logic                  sweep_reply_ff, sweep_reply_in;

   // state register; reset starts the clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= FSM_SWEEP;
         sweep_cnt_ff   <= '0;
         sweep_reply_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         sweep_cnt_ff   <= sweep_cnt_in;
         sweep_reply_ff <= sweep_reply_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in        = state_ff;
      sweep_cnt_in    = sweep_cnt_ff;
      sweep_reply_in  = sweep_reply_ff;
      req_ready       = 1'b0;
      cmd.capture     = 1'b0;
      cmd.execute     = 1'b0;
      cmd.sweep_write = 1'b0;
      cmd.sweep_addr  = sweep_cnt_ff;
      cmd.load_clear  = 1'b0;
      unique case (state_ff)
         FSM_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (req_opcode == OP_CLEAR) begin
                  state_in       = FSM_SWEEP;
                  sweep_cnt_in   = '0;
                  sweep_reply_in = 1'b1;
               end else begin
                  state_in = FSM_LOOKUP;
               end
            end
         end
         FSM_LOOKUP: begin
            if (status.out_free) begin
               cmd.execute = 1'b1;
               state_in    = FSM_IDLE;
            end
         end
         FSM_SWEEP: begin
            cmd.sweep_write = 1'b1;
            if (sweep_cnt_ff == LAST_SLOT) begin
               state_in = sweep_reply_ff ? FSM_REPLY : FSM_IDLE;
            end else begin
               sweep_cnt_in = sweep_cnt_ff + 1'b1;
            end
         end
         FSM_REPLY: begin
            if (status.out_free) begin
               cmd.load_clear = 1'b1;
               sweep_reply_in = 1'b0;
               state_in       = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   // a result is only produced when the output register can take it
   a_load_needs_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.execute || cmd.load_clear) |-> status.out_free)
      else $error("result loaded while output register is occupied");

   // the sweep visits slots in order without skipping
   a_sweep_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == FSM_SWEEP && sweep_cnt_ff != LAST_SLOT)
      |=> (state_ff == FSM_SWEEP && sweep_cnt_ff == $past(sweep_cnt_ff) + 1'b1))
      else $error("clearing sweep skipped or left early");

   // leaving reset, the table is cleared from slot zero
   a_reset_sweep: assert property (@(posedge clock)
      $fell(reset) |-> (state_ff == FSM_SWEEP && sweep_cnt_ff == '0 && !sweep_reply_ff))
      else $error("clearing pass does not start at reset");

   // a lookup always finishes before the next request is taken
   a_lookup_then_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.execute |=> (state_ff == FSM_IDLE))
      else $error("lookup did not return to idle");
`endif

endmodule

// File: rtl/hpt_datapath.sv
// hashed position table: key hash, slot memory, update logic, result register
// depends on hpt_pkg; sequenced by hpt_ctrl through the command struct

module hpt_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  hpt_pkg::ctrl_cmd_type            cmd,
   output hpt_pkg::dp_status_type           status,
   input  logic [hpt_pkg::OPCODE_BITS-1:0]  req_opcode,
   input  logic [hpt_pkg::KEY_BITS-1:0]     req_key_word0,
   input  logic [hpt_pkg::KEY_BITS-1:0]     req_key_word1,
   input  logic [hpt_pkg::KEY_BITS-1:0]     req_key_word2,
   input  logic [hpt_pkg::KEY_BITS-1:0]     req_key_word3,
   input  logic [hpt_pkg::WORD_BITS-1:0]    req_new_position,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [hpt_pkg::STATUS_BITS-1:0]  rsp_status,
   output logic [hpt_pkg::WORD_BITS-1:0]    rsp_found_position
);
   import hpt_pkg::*;

   logic [WORD_BITS-1:0]   slot_mem [TABLE_ENTRIES];

   logic [INDEX_BITS-1:0]  hash_idx;
   logic [OPCODE_BITS-1:0] op_ff, op_in;
   logic [WORD_BITS-1:0]   pos_ff, pos_in;
   logic [INDEX_BITS-1:0]  idx_ff, idx_in;
   logic [WORD_BITS-1:0]   cur_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [WORD_BITS-1:0]   rsp_found_ff, rsp_found_in;

   logic                   exec_we;
   logic [WORD_BITS-1:0]   exec_data;
   status_type             exec_status;
   logic [WORD_BITS-1:0]   exec_found;
   logic [63:0]            cur_wide;
   logic [63:0]            pos_wide;

   logic                   wr_en;
   logic [INDEX_BITS-1:0]  wr_addr;
   logic [WORD_BITS-1:0]   wr_data;

   // slot index: low bits of the sum of the eight 32-bit key words
   assign hash_idx = req_key_word0[INDEX_BITS-1:0] + req_key_word0[32 +: INDEX_BITS]
                   + req_key_word1[INDEX_BITS-1:0] + req_key_word1[32 +: INDEX_BITS]
                   + req_key_word2[INDEX_BITS-1:0] + req_key_word2[32 +: INDEX_BITS]
                   + req_key_word3[INDEX_BITS-1:0] + req_key_word3[32 +: INDEX_BITS];

   // request capture
   always_comb begin
      op_in  = op_ff;
      pos_in = pos_ff;
      idx_in = idx_ff;
      if (cmd.capture) begin
         op_in  = req_opcode;
         pos_in = req_new_position;
         idx_in = hash_idx;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      pos_ff <= pos_in;
      idx_ff <= idx_in;
   end

   // slot memory: registered read at capture, one write port
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cur_ff <= slot_mem[hash_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
   end

   // operation on the slot just read
   assign cur_wide = {32'd0, cur_ff};
   assign pos_wide = {32'd0, pos_ff};

   always_comb begin
      exec_we     = 1'b0;
      exec_data   = pos_ff;
      exec_status = ST_OK;
      exec_found  = NULL_MARK;
      unique case (op_ff)
         OP_GET: begin
            if (cur_ff == SEARCH_MARK) begin
               exec_status = ST_SEARCH;
            end else if (cur_ff == NULL_MARK) begin
               exec_status = ST_NOENT;
            end else begin
               exec_found = cur_ff;
            end
         end
         OP_SET: begin
            if (pos_wide >= POS_LIMIT) begin
               exec_status = ST_INVALID;
            end else if (cur_wide < pos_wide || cur_wide >= POS_LIMIT) begin
               exec_we = 1'b1;
            end
         end
         OP_UNSET: begin
            exec_we   = 1'b1;
            exec_data = NULL_MARK;
         end
         OP_RESET: begin
            exec_we   = 1'b1;
            exec_data = SEARCH_MARK;
         end
         default: begin
            exec_we = 1'b0;
         end
      endcase
   end

   // write port: clearing sweep or update
   always_comb begin
      wr_en   = cmd.sweep_write || (cmd.execute && exec_we);
      wr_addr = cmd.sweep_write ? cmd.sweep_addr : idx_ff;
      wr_data = cmd.sweep_write ? SEARCH_MARK : exec_data;
   end

   // result register
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_found_in  = rsp_found_ff;
      if (cmd.execute) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = exec_status;
         rsp_found_in  = exec_found;
      end else if (cmd.load_clear) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = ST_OK;
         rsp_found_in  = NULL_MARK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_found_ff  <= rsp_found_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_found_position = rsp_found_ff;

endmodule

// File: rtl/hashed_position_table_unit.sv
// hashed position table: top level, joins controller and datapath to the channels
// depends on hpt_pkg, hpt_if, hpt_ctrl and hpt_datapath

// A direct-mapped table of 4096 record positions, indexed by the low 12 bits of
// the sum of the key's eight 32-bit words. Get, set, unset and reset read the slot
// into a register in the accept cycle, and the lookup state then does the
// read-modify-write and loads the response word, waiting while an earlier
// response is still untaken. Clear walks the slot memory one slot a cycle
// through its single write port and then answers. After reset the same clearing
// pass runs with req.ready low before the first request is taken. Opcodes above
// clear change nothing and answer ok.

module hashed_position_table_unit (
   input  logic        clock,
   input  logic        reset,
   hpt_req_if.sink     req,
   hpt_rsp_if.source   rsp
);
   import hpt_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type dp_status;
   logic          ctrl_ready;

   hpt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req.valid),
      .req_opcode (req.opcode),
      .req_ready  (ctrl_ready),
      .status     (dp_status),
      .cmd        (cmd)
   );

   hpt_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (dp_status),
      .req_opcode         (req.opcode),
      .req_key_word0      (req.key_word0),
      .req_key_word1      (req.key_word1),
      .req_key_word2      (req.key_word2),
      .req_key_word3      (req.key_word3),
      .req_new_position   (req.new_position),
      .rsp_valid          (rsp.valid),
      .rsp_ready          (rsp.ready),
      .rsp_status         (rsp.status),
      .rsp_found_position (rsp.found_position)
   );

   assign req.ready = ctrl_ready;

endmodule
